FILE: rtl/pvt_pkg.sv
package pvt_pkg;

    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 16;

    // Common width for size comparisons; holds any row or column count.
    localparam int SZ_W       = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [3:0] ROWS_RESET = 4'd8;
    localparam logic [4:0] COLS_RESET = 5'd16;

    localparam logic [31:0] EMPTY_ENTRY  = 32'hFFFF_FFFF;
    localparam logic [31:0] EMPTY_ANSWER = 32'd999;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_CLR_ROW = 2'd1,
        REQ_VOTE    = 2'd2,
        REQ_CLR_ALL = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_UNIQUE = 2'd0,
        ST_TIE    = 2'd1,
        ST_EMPTY  = 2'd2
    } t_status;

    typedef struct packed {
        logic wr_entry;
        logic clr_start_row;
        logic clr_start_all;
        logic clr_step;
        logic vote_start;
        logic rd_i;
        logic scan_start;
        logic scan_rd;
        logic upd_best;
        logic i_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic row_ok;
        logic col_ok;
        logic cols_zero;
        logic clr_last;
        logic v_empty;
        logic j_last;
        logic i_last;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/pvt_req_if.sv
interface pvt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [2:0]  row_index;
    logic [3:0]  col_index;
    logic [31:0] entry_value;

    modport source (output valid, output req_type, output row_index,
                    output col_index, output entry_value, input ready);
    modport sink   (input valid, input req_type, input row_index,
                    input col_index, input entry_value, output ready);
endinterface

FILE: rtl/pvt_res_if.sv
interface pvt_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] vote_result;
    logic [1:0]  vote_status;

    modport source (output valid, output vote_result, output vote_status, input ready);
    modport sink   (input valid, input vote_result, input vote_status, output ready);
endinterface

FILE: rtl/pvt_ctrl.sv
module pvt_ctrl
    import pvt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic [1:0] i_req_type,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_req_ready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_RDI,
        S_WTI,
        S_SCAN,
        S_TAIL,
        S_UPD,
        S_NXT,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    case (t_req'(i_req_type))
                        REQ_WRITE: begin
                            o_cmd.wr_entry = i_stat.row_ok && i_stat.col_ok;
                        end
                        REQ_CLR_ROW: begin
                            if (i_stat.row_ok) begin
                                o_cmd.clr_start_row = 1'b1;
                                n_state             = S_CLR;
                            end
                        end
                        REQ_VOTE: begin
                            o_cmd.vote_start = 1'b1;
                            if (i_stat.row_ok && !i_stat.cols_zero) begin
                                n_state = S_RDI;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        REQ_CLR_ALL: begin
                            o_cmd.clr_start_all = 1'b1;
                            n_state             = S_CLR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RDI: begin
                o_cmd.rd_i = 1'b1;
                n_state    = S_WTI;
            end
            S_WTI: begin
                o_cmd.scan_start = 1'b1;
                // An empty slot takes no part in the count.
                n_state = i_stat.v_empty ? S_NXT : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.j_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_best = 1'b1;
                n_state        = S_NXT;
            end
            S_NXT: begin
                if (i_stat.i_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_RDI;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Reset starts with a clearing pass over the whole matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/pvt_dpath.sv
module pvt_dpath
    import pvt_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [2:0]            i_row_index,
    input  logic [3:0]            i_col_index,
    input  logic [31:0]           i_entry_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_vote_result,
    output logic [1:0]            o_vote_status
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = $clog2(MAX_COLS + 1);

    localparam logic [SZ_W-1:0]   MAXR      = SZ_W'(MAX_ROWS);
    localparam logic [SZ_W-1:0]   MAXC      = SZ_W'(MAX_COLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    logic [3:0]        r_rows;
    logic [4:0]        r_cols;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_ctr;
    logic              r_clr_row_mode;
    logic [COL_W-1:0]  r_i;
    logic [COL_W-1:0]  r_j;
    logic [31:0]       r_v;
    logic              r_cmp_v;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_best;
    logic [31:0]       r_best_val;
    logic              r_tie;
    logic              r_out_valid;
    logic [31:0]       r_result;
    logic [1:0]        r_status;

    logic [SZ_W-1:0]   urows;
    logic [SZ_W-1:0]   ucols;
    logic [SZ_W-1:0]   row_ext;
    logic [SZ_W-1:0]   col_ext;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] clr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;

    // Size registers above the maximum saturate.
    assign urows   = (SZ_W'(r_rows) > MAXR) ? MAXR : SZ_W'(r_rows);
    assign ucols   = (SZ_W'(r_cols) > MAXC) ? MAXC : SZ_W'(r_cols);
    assign row_ext = SZ_W'(i_row_index);
    assign col_ext = SZ_W'(i_col_index);

    assign wr_addr  = {row_ext[ROW_W-1:0], col_ext[COL_W-1:0]};
    assign clr_addr = r_clr_row_mode ? {r_row, r_ctr[COL_W-1:0]} : r_ctr;
    assign rd_addr  = i_cmd.scan_rd ? {r_row, r_j} : {r_row, r_i};

    always_comb begin
        mem_we    = i_cmd.wr_entry || i_cmd.clr_step;
        mem_waddr = i_cmd.clr_step ? clr_addr : wr_addr;
        mem_wdata = i_cmd.clr_step ? EMPTY_ENTRY : i_entry_value;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_i || i_cmd.scan_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        o_stat.row_ok    = row_ext < urows;
        o_stat.col_ok    = col_ext < ucols;
        o_stat.cols_zero = (ucols == '0);
        o_stat.clr_last  = r_clr_row_mode ? (r_ctr[COL_W-1:0] == '1)
                                          : (r_ctr == LAST_ADDR);
        o_stat.v_empty   = (r_rdata == EMPTY_ENTRY);
        o_stat.j_last    = (SZ_W'(r_j) == ucols - 1'b1);
        o_stat.i_last    = (SZ_W'(r_i) == ucols - 1'b1);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows         <= ROWS_RESET;
            r_cols         <= COLS_RESET;
            r_ctr          <= '0;
            r_clr_row_mode <= 1'b0;
            r_cmp_v        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_ROWS) begin
                r_rows <= i_cfg_data[3:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_COLS) begin
                r_cols <= i_cfg_data;
            end
            if (i_cmd.clr_start_row || i_cmd.clr_start_all) begin
                r_ctr          <= '0;
                r_clr_row_mode <= i_cmd.clr_start_row;
            end else if (i_cmd.clr_step) begin
                r_ctr <= r_ctr + 1'b1;
            end
            r_cmp_v <= i_cmd.scan_rd;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Vote datapath.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_start_row || i_cmd.vote_start) begin
            r_row <= row_ext[ROW_W-1:0];
        end
        if (i_cmd.vote_start) begin
            r_i    <= '0;
            r_best <= '0;
            r_tie  <= 1'b0;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.scan_start) begin
            r_v   <= r_rdata;
            r_j   <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_j <= r_j + 1'b1;
            end
            if (r_cmp_v && r_rdata == r_v) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
        if (i_cmd.upd_best) begin
            if (r_cnt > r_best) begin
                r_best     <= r_cnt;
                r_best_val <= r_v;
                r_tie      <= 1'b0;
            end else if (r_cnt == r_best && r_v != r_best_val) begin
                r_tie <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            if (r_best == '0) begin
                r_result <= EMPTY_ANSWER;
                r_status <= ST_EMPTY;
            end else if (r_tie) begin
                r_result <= '0;
                r_status <= ST_TIE;
            end else begin
                r_result <= r_best_val;
                r_status <= ST_UNIQUE;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_vote_result = r_result;
    assign o_vote_status = r_status;

endmodule

FILE: rtl/plurality_vote_table.sv
// Write beat: taken straight from the idle state. Clear row: fills every slot of the row
// with the empty marker. Clear all: does the same for every slot of the matrix.
// A vote over n columns is paced by the one read port of the matrix memory, read
// once per compared entry.
// Synchronous active-low reset sets the size registers to 8 and 16 and starts a
// clearing pass over the whole matrix before the first beat.
module plurality_vote_table
    import pvt_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pvt_req_if.sink               i_req,
    pvt_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    pvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_req_ready (i_req.ready)
    );

    pvt_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_row_index   (i_req.row_index),
        .i_col_index   (i_req.col_index),
        .i_entry_value (i_req.entry_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_res.valid),
        .i_out_ready   (o_res.ready),
        .o_vote_result (o_res.vote_result),
        .o_vote_status (o_res.vote_status)
    );

    // The matrix is being cleared right after reset, so no beat is taken.
    a_reset_blocks: assert property (@(posedge i_clk) !i_rst_n |=> !i_req.ready)
        else $error("request accepted during the clearing pass after reset");

    a_vote_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && i_req.req_type == REQ_VOTE |=> !i_req.ready)
        else $error("new request accepted while a vote is running");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_res.valid || o_res.ready))
        else $error("result overwritten before it was taken");

    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.vote_status == ST_EMPTY |-> o_res.vote_result == EMPTY_ANSWER)
        else $error("empty status without the empty answer");

endmodule

FILE: tb/tb_plurality_vote_table.sv
module tb_plurality_vote_table;
    import pvt_pkg::*;

    localparam int DRAIN_WAIT   = 400;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int PHASE_ITEMS  = 200;

    typedef struct packed {
        t_req        kind;
        logic [2:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
    } req_item_t;

    typedef struct packed {
        logic [31:0] result;
        t_status     status;
    } vote_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic      drv_valid = 1'b0;
    req_item_t drv_item  = '0;
    req_item_t next_item;
    int        drv_gap   = 0;
    int        drv_gap_max = 0;

    logic  mon_ready = 1'b0;
    int    mon_stall = 0;
    int    stall_draw;
    int    res_stall_max = 0;
    vote_t seen_vote;
    vote_t want_vote;

    // Shadow copy of the table and its size registers.
    logic [31:0] tally_mx [DEF_MAX_ROWS][DEF_MAX_COLS];
    logic [3:0]  rows_cfg = ROWS_RESET;
    logic [4:0]  cols_cfg = COLS_RESET;

    req_item_t req_pending_q[$];
    vote_t     vote_expect_q[$];

    int mismatches = 0;
    int cycles     = 0;

    pvt_req_if req_if ();
    pvt_res_if res_if ();

    assign req_if.valid       = drv_valid;
    assign req_if.req_type    = drv_item.kind;
    assign req_if.row_index   = drv_item.row;
    assign req_if.col_index   = drv_item.col;
    assign req_if.entry_value = drv_item.value;
    assign res_if.ready       = mon_ready;

    plurality_vote_table u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int used_rows();
        return (rows_cfg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_cfg);
    endfunction

    function automatic int used_cols();
        return (cols_cfg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_cfg);
    endfunction

    function automatic void clear_matrix();
        for (int r = 0; r < DEF_MAX_ROWS; r++)
            for (int c = 0; c < DEF_MAX_COLS; c++)
                tally_mx[r][c] = EMPTY_ENTRY;
    endfunction

    function automatic vote_t tally_row(int row);
        vote_t       ans;
        int          n;
        int          best;
        int          cnt;
        logic [31:0] v;
        logic [31:0] best_val;
        logic        tie;
        n        = used_cols();
        best     = 0;
        best_val = '0;
        tie      = 1'b0;
        for (int i = 0; i < n; i++) begin
            v = tally_mx[row][i];
            if (v != EMPTY_ENTRY) begin
                cnt = 0;
                for (int j = 0; j < n; j++)
                    if (tally_mx[row][j] == v) cnt++;
                if (cnt > best) begin
                    best     = cnt;
                    best_val = v;
                    tie      = 1'b0;
                end else if (cnt == best && v != best_val) begin
                    tie = 1'b1;
                end
            end
        end
        if (best == 0) begin
            ans.result = EMPTY_ANSWER;
            ans.status = ST_EMPTY;
        end else if (tie) begin
            ans.result = '0;
            ans.status = ST_TIE;
        end else begin
            ans.result = best_val;
            ans.status = ST_UNIQUE;
        end
        return ans;
    endfunction

    // Updates the shadow table for one accepted beat and, for a vote, queues the answer.
    function automatic void apply_request(req_item_t it);
        vote_t ans;
        int    ur;
        int    uc;
        ur = used_rows();
        uc = used_cols();
        case (it.kind)
            REQ_WRITE: begin
                if (int'(it.row) < ur && int'(it.col) < uc)
                    tally_mx[it.row][it.col] = it.value;
            end
            REQ_CLR_ROW: begin
                if (int'(it.row) < ur)
                    for (int c = 0; c < DEF_MAX_COLS; c++)
                        tally_mx[it.row][c] = EMPTY_ENTRY;
            end
            REQ_VOTE: begin
                if (int'(it.row) < ur) begin
                    ans = tally_row(int'(it.row));
                end else begin
                    ans.result = EMPTY_ANSWER;
                    ans.status = ST_EMPTY;
                end
                vote_expect_q.insert(vote_expect_q.size(), ans);
            end
            default: clear_matrix();
        endcase
    endfunction

    // Queues one request; returns the number of beats it adds.
    function automatic int push_req(t_req kind, int row, int col, logic [31:0] value);
        req_item_t it;
        it.kind  = kind;
        it.row   = row[2:0];
        it.col   = col[3:0];
        it.value = value;
        req_pending_q.insert(req_pending_q.size(), it);
        return 1;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return EMPTY_ENTRY;
            1:       return EMPTY_ANSWER;
            2:       return '0;
            3, 4, 5: return 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic drained();
        return req_pending_q.size() == 0 && !drv_valid && vote_expect_q.size() == 0;
    endfunction

    // Waits for the last answer, then long enough for a trailing clear to finish.
    task automatic settle();
        while (!drained()) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_ROWS)
            rows_cfg = data[3:0];
        else
            cols_cfg = data;
    endtask

    task automatic run_phase(int rows, int cols, int gap_max, int stall_max, int target);
        int          eff;
        int          ur;
        int          uc;
        int          row;
        int          col;
        int          npool;
        int          nwr;
        t_req        kind;
        logic [31:0] pool [3];
        settle();
        write_reg(CFG_ROWS, rows[CFG_DATA_W-1:0]);
        write_reg(CFG_COLS, cols[CFG_DATA_W-1:0]);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        drv_gap_max   = gap_max;
        res_stall_max = stall_max;
        ur  = used_rows();
        uc  = used_cols();
        eff = 0;
        while (eff < target) begin
            if ($urandom_range(0, 9) < 2) begin
                // Noise: any request, any address; clear-all kept rare.
                kind = t_req'($urandom_range(0, 3));
                if (kind == REQ_CLR_ALL && $urandom_range(0, 7) != 0)
                    kind = REQ_VOTE;
                eff += push_req(kind, $urandom_range(0, 7), $urandom_range(0, 15),
                                pick_value());
            end else begin
                // Maybe clear a row, fill part of it from a small set of values, then vote on it.
                if ($urandom_range(0, 9) == 0 || ur == 0)
                    row = $urandom_range(0, 7);
                else
                    row = $urandom_range(0, ur - 1);
                if ($urandom_range(0, 3) == 0)
                    eff += push_req(REQ_CLR_ROW, row, $urandom_range(0, 15), pick_value());
                npool = $urandom_range(1, 3);
                for (int p = 0; p < 3; p++)
                    pool[p] = pick_value();
                nwr = $urandom_range(1, uc + 2);
                for (int k = 0; k < nwr; k++) begin
                    if ($urandom_range(0, 9) == 0 || uc == 0)
                        col = $urandom_range(0, 15);
                    else
                        col = $urandom_range(0, uc - 1);
                    eff += push_req(REQ_WRITE, row, col, pool[$urandom_range(0, npool - 1)]);
                end
                eff += push_req(REQ_VOTE, row, $urandom_range(0, 15), $urandom);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset sizes of 8 rows by 16 columns.
        drv_gap_max   = 7;
        res_stall_max = 7;
        void'(push_req(REQ_VOTE,    0, 0,  '0));
        void'(push_req(REQ_WRITE,   0, 0,  32'd5));
        void'(push_req(REQ_WRITE,   0, 15, 32'd5));
        void'(push_req(REQ_WRITE,   0, 7,  32'd7));
        void'(push_req(REQ_VOTE,    0, 0,  '0));
        void'(push_req(REQ_WRITE,   0, 3,  32'd7));
        void'(push_req(REQ_VOTE,    0, 0,  '0));
        void'(push_req(REQ_WRITE,   0, 0,  EMPTY_ENTRY));
        void'(push_req(REQ_VOTE,    0, 0,  '0));
        void'(push_req(REQ_WRITE,   7, 15, '0));
        void'(push_req(REQ_VOTE,    7, 0,  '0));
        void'(push_req(REQ_WRITE,   1, 2,  EMPTY_ANSWER));
        void'(push_req(REQ_VOTE,    1, 0,  '0));
        void'(push_req(REQ_CLR_ROW, 0, 0,  '0));
        void'(push_req(REQ_VOTE,    0, 0,  '0));
        void'(push_req(REQ_WRITE,   2, 4,  32'h8000_0001));
        void'(push_req(REQ_WRITE,   2, 5,  32'h7FFF_FFFE));
        void'(push_req(REQ_VOTE,    2, 0,  '0));
        void'(push_req(REQ_WRITE,   2, 6,  32'h7FFF_FFFE));
        void'(push_req(REQ_VOTE,    2, 0,  '0));
        void'(push_req(REQ_CLR_ALL, 0, 0,  '0));
        void'(push_req(REQ_VOTE,    7, 0,  '0));
        void'(push_req(REQ_VOTE,    2, 0,  '0));

        run_phase(8,  16, 7, 7, PHASE_ITEMS);
        run_phase(1,  1,  0, 0, PHASE_ITEMS);
        run_phase(0,  16, 7, 0, PHASE_ITEMS);
        run_phase(8,  0,  0, 7, PHASE_ITEMS);
        run_phase(15, 31, 7, 7, PHASE_ITEMS);
        // Bit 4 of the row count is dropped, so 24 selects all 8 rows.
        run_phase(24, 5,  7, 7, PHASE_ITEMS);
        run_phase(3,  2,  7, 0, PHASE_ITEMS);
        run_phase($urandom_range(0, 15), $urandom_range(0, 31), 0, 0, PHASE_ITEMS);
        run_phase($urandom_range(0, 15), $urandom_range(0, 31), 7, 7, PHASE_ITEMS);

        settle();
        if (mismatches == 0 && vote_expect_q.size() == 0) begin
            $display("plurality_vote_table regression: pass");
        end else begin
            $display("plurality_vote_table regression: fail");
        end
        $finish;
    end

    // Request driver: one beat at a time, with a random pause after each beat.
    always @(posedge clk) begin
        if (!rst_n) begin
            clear_matrix();
            drv_valid <= 1'b0;
            drv_gap   <= 0;
        end else begin
            if (drv_valid && req_if.ready)
                apply_request(drv_item);
            if (!drv_valid || req_if.ready) begin
                if (drv_gap != 0) begin
                    drv_gap   <= drv_gap - 1;
                    drv_valid <= 1'b0;
                end else if (req_pending_q.size() != 0) begin
                    next_item = req_pending_q.pop_front();
                    drv_item  <= next_item;
                    drv_valid <= 1'b1;
                    drv_gap   <= $urandom_range(0, drv_gap_max);
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each beat against the oldest expected answer.
    always @(posedge clk) begin
        if (!rst_n) begin
            mon_ready <= 1'b0;
            mon_stall <= 0;
        end else if (res_if.valid && mon_ready) begin
            seen_vote.result = res_if.vote_result;
            seen_vote.status = t_status'(res_if.vote_status);
            if (vote_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vote beat: result %h status %0d",
                             seen_vote.result, seen_vote.status);
            end else begin
                want_vote = vote_expect_q.pop_front();
                if (seen_vote.result !== want_vote.result ||
                    seen_vote.status !== want_vote.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vote mismatch: expected %h/%0d, got %h/%0d",
                                 want_vote.result, want_vote.status,
                                 seen_vote.result, seen_vote.status);
                end
            end
            stall_draw = $urandom_range(0, res_stall_max);
            mon_stall <= stall_draw;
            mon_ready <= (stall_draw == 0);
        end else if (mon_stall != 0) begin
            mon_stall <= mon_stall - 1;
            mon_ready <= (mon_stall == 1);
        end else begin
            mon_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("plurality_vote_table regression: fail");
            $finish;
        end
    end

endmodule
